FILE: src/wdvs_pkg.sv
// shared types, codes and constants of the wav data chunk volume stream
package wdvs_pkg;

  localparam int unsigned PADDR_W = 3;
  localparam logic VOLUME_REG = 1'b0;
  localparam logic [7:0] VOLUME_RESET = 8'd6;

  localparam logic [2:0] KIND_SAMPLE  = 3'd0;
  localparam logic [2:0] KIND_DONE    = 3'd1;
  localparam logic [2:0] KIND_BADTAG  = 3'd2;
  localparam logic [2:0] KIND_OVERRUN = 3'd3;
  localparam logic [2:0] KIND_NODATA  = 3'd4;
  localparam logic [2:0] KIND_SHORT   = 3'd5;

  // tags packed with byte 0 in the low lane
  localparam logic [31:0] RIFF_TAG = 32'h4646_4952;
  localparam logic [31:0] WAVE_TAG = 32'h4556_4157;
  localparam logic [31:0] DATA_TAG = 32'h6174_6164;

  localparam logic [31:0] MIN_FILE_SIZE = 32'd44;
  localparam logic [31:0] FIRST_CHUNK   = 32'd12;
  localparam logic [32:0] CHUNK_HDR_LEN = 33'd8;

  localparam int unsigned GAIN_DIV    = 10;
  localparam int unsigned RECIP_SHIFT = 27;
  localparam int unsigned RECIP_MUL   = ((2 ** RECIP_SHIFT) + GAIN_DIV - 1) / GAIN_DIV;
  localparam int unsigned MAG_W       = 24;
  localparam int unsigned RPROD_W     = 2 * MAG_W;
  localparam int unsigned QUOT_W      = RPROD_W - RECIP_SHIFT;

  localparam logic [QUOT_W-1:0] POS_LIMIT = QUOT_W'(32767);
  localparam logic [QUOT_W-1:0] NEG_LIMIT = QUOT_W'(32768);

  typedef struct packed {
    logic signed [15:0] raw;
    logic [2:0]         kind;
    logic               last;
  } tok_t;

  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
    tag_byte = tag[{idx, 3'b000} +: 8];
  endfunction

endpackage

FILE: src/wav_data_chunk_volume_stream.sv
// top level: wav data chunk parser with volume gain and apb volume register
// Takes one file byte per clock, back to back, as long as the output side keeps
// up; the parser token for a byte is registered, then the volume product, then
// the divide-by-ten and saturate result in the output register, and the sustained
// rate of one byte per cycle holds as the parser updates its state on each byte.
// The volume register (reset 6) sits at address 0; the user must see that it is
// written only while no file is in flight, as the block does not enforce this.
module wav_data_chunk_volume_stream import wdvs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic [31:0]        file_size,
  input  logic               first_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample,
  output logic [2:0]         kind,
  output logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [7:0] volume;
  logic       accept;
  logic       tok_valid;
  tok_t       tok;

  assign accept = in_valid && in_ready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == VOLUME_REG) ? {24'b0, volume} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      volume <= VOLUME_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == VOLUME_REG) begin
      volume <= pwdata[7:0];
    end
  end

  wdvs_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .file_size  (file_size),
    .first_byte (first_byte),
    .tok_valid  (tok_valid),
    .tok        (tok)
  );

  wdvs_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok       (tok),
    .volume    (volume),
    .take      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample),
    .kind      (kind),
    .last      (last)
  );

endmodule

FILE: src/wdvs_parser.sv
// byte-wise riff/wave header and chunk walker producing raw sample and status words
module wdvs_parser import wdvs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic [31:0] file_size,
  input  logic        first_byte,
  output logic        tok_valid,
  output tok_t        tok
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_CHUNKHDR,
    PH_SKIP,
    PH_DATA
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] byte_position, byte_position_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [3:0]  tag_match, tag_match_next;
  logic [32:0] bytes_left, bytes_left_next;
  logic [7:0]  low_sample_byte, low_sample_byte_next;

  logic [2:0]  hdr_idx;
  logic [33:0] chunk_end;
  logic [33:0] next_hdr;
  logic        bad_tag;

  always_comb begin
    phase_next           = phase;
    byte_position_next   = byte_position;
    chunk_length_next    = chunk_length;
    tag_match_next       = tag_match;
    bytes_left_next      = bytes_left;
    low_sample_byte_next = low_sample_byte;
    tok_valid            = 1'b0;
    tok                  = '0;
    hdr_idx              = 3'(4'd8 - bytes_left[3:0]);
    chunk_end            = '0;
    next_hdr             = '0;
    bad_tag              = 1'b0;

    if (accept) begin
      if (first_byte) begin
        byte_position_next   = '0;
        chunk_length_next    = '0;
        tag_match_next       = '0;
        bytes_left_next      = '0;
        low_sample_byte_next = '0;
        if (file_size < MIN_FILE_SIZE) begin
          tok_valid = 1'b1;
          tok.kind  = KIND_SHORT;
          tok.last  = 1'b1;
        end else begin
          phase_next = PH_HEADER;
        end
      end

      if (!tok_valid) begin
        case (phase_next)
          PH_HEADER: begin
            if (byte_position_next < 32'd4 &&
                data_byte != tag_byte(RIFF_TAG, byte_position_next[1:0])) begin
              bad_tag = 1'b1;
            end
            if (byte_position_next >= 32'd8 && byte_position_next < FIRST_CHUNK &&
                data_byte != tag_byte(WAVE_TAG, byte_position_next[1:0])) begin
              bad_tag = 1'b1;
            end
            if (bad_tag) begin
              tok_valid = 1'b1;
              tok.kind  = KIND_BADTAG;
              tok.last  = 1'b1;
            end else if (byte_position_next >= FIRST_CHUNK - 32'd1) begin
              byte_position_next = FIRST_CHUNK;
              phase_next         = PH_CHUNKHDR;
              bytes_left_next    = CHUNK_HDR_LEN;
              tag_match_next     = '0;
              chunk_length_next  = '0;
            end else begin
              byte_position_next = byte_position_next + 32'd1;
            end
          end
          PH_CHUNKHDR: begin
            hdr_idx = 3'(4'd8 - bytes_left_next[3:0]);
            if (!hdr_idx[2]) begin
              if (data_byte == tag_byte(DATA_TAG, hdr_idx[1:0])) begin
                tag_match_next[hdr_idx[1:0]] = 1'b1;
              end
            end else begin
              chunk_length_next[{hdr_idx[1:0], 3'b000} +: 8] =
                chunk_length_next[{hdr_idx[1:0], 3'b000} +: 8] | data_byte;
            end
            bytes_left_next = bytes_left_next - 33'd1;
            if (bytes_left_next == '0) begin
              chunk_end = {2'b00, byte_position_next} + {1'b0, CHUNK_HDR_LEN}
                          + {2'b00, chunk_length_next};
              next_hdr  = chunk_end + {33'b0, chunk_length_next[0]};
              if (chunk_end > {2'b00, file_size}) begin
                tok_valid = 1'b1;
                tok.kind  = KIND_OVERRUN;
                tok.last  = 1'b1;
              end else if (tag_match_next == 4'hF) begin
                bytes_left_next = {1'b0, chunk_length_next[31:1], 1'b0};
                if (bytes_left_next == '0) begin
                  tok_valid = 1'b1;
                  tok.kind  = KIND_DONE;
                  tok.last  = 1'b1;
                end else begin
                  phase_next = PH_DATA;
                end
              end else if (next_hdr + {1'b0, CHUNK_HDR_LEN} > {2'b00, file_size}) begin
                tok_valid = 1'b1;
                tok.kind  = KIND_NODATA;
                tok.last  = 1'b1;
              end else begin
                byte_position_next = next_hdr[31:0];
                if (chunk_length_next == '0) begin
                  phase_next        = PH_CHUNKHDR;
                  bytes_left_next   = CHUNK_HDR_LEN;
                  tag_match_next    = '0;
                  chunk_length_next = '0;
                end else begin
                  bytes_left_next = {1'b0, chunk_length_next}
                                    + {32'b0, chunk_length_next[0]};
                  phase_next      = PH_SKIP;
                end
              end
            end
          end
          PH_SKIP: begin
            if (bytes_left_next != '0) begin
              bytes_left_next = bytes_left_next - 33'd1;
            end
            if (bytes_left_next == '0) begin
              phase_next        = PH_CHUNKHDR;
              bytes_left_next   = CHUNK_HDR_LEN;
              tag_match_next    = '0;
              chunk_length_next = '0;
            end
          end
          PH_DATA: begin
            if (bytes_left_next == '0) begin
              phase_next = PH_IDLE;
            end else if (!bytes_left_next[0]) begin
              low_sample_byte_next = data_byte;
              bytes_left_next      = bytes_left_next - 33'd1;
            end else begin
              bytes_left_next = bytes_left_next - 33'd1;
              tok_valid       = 1'b1;
              tok.raw         = {data_byte, low_sample_byte_next};
              tok.kind        = KIND_SAMPLE;
              tok.last        = (bytes_left_next == '0);
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end

      if (tok_valid && tok.last) begin
        phase_next = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      byte_position   <= '0;
      chunk_length    <= '0;
      tag_match       <= '0;
      bytes_left      <= '0;
      low_sample_byte <= '0;
    end else begin
      phase           <= phase_next;
      byte_position   <= byte_position_next;
      chunk_length    <= chunk_length_next;
      tag_match       <= tag_match_next;
      bytes_left      <= bytes_left_next;
      low_sample_byte <= low_sample_byte_next;
    end
  end

  a_hdr_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_CHUNKHDR |-> bytes_left != '0 && bytes_left <= CHUNK_HDR_LEN)
    else $error("chunk header count out of range");

  a_body_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SKIP || phase == PH_DATA) |-> bytes_left != '0)
    else $error("skip or data phase with nothing left");

  a_only_last_status: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok.kind != KIND_SAMPLE |-> tok.last)
    else $error("status word without last");

endmodule

FILE: src/wdvs_scale.sv
// gain pipeline: volume multiply, divide by ten, saturate, output register
module wdvs_scale import wdvs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               tok_valid,
  input  tok_t               tok,
  input  logic [7:0]         volume,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample,
  output logic [2:0]         kind,
  output logic               last
);

  logic               a_valid;
  tok_t               a_tok;
  logic               b_valid;
  logic signed [24:0] b_prod;
  logic [2:0]         b_kind;
  logic               b_last;

  logic               en_a, en_b, en_c;
  logic               neg;
  logic [MAG_W-1:0]   mag;
  logic [RPROD_W-1:0] rprod;
  logic [QUOT_W-1:0]  quot;
  logic signed [15:0] sat;

  assign en_c = !out_valid || out_ready;
  assign en_b = !b_valid || en_c;
  assign en_a = !a_valid || en_b;
  assign take = en_a;

  always_comb begin
    neg   = b_prod[24];
    mag   = neg ? MAG_W'(-b_prod) : MAG_W'(b_prod);
    rprod = {{MAG_W{1'b0}}, mag} * RPROD_W'(RECIP_MUL);
    quot  = rprod[RPROD_W-1:RECIP_SHIFT];
    if (!neg && quot > POS_LIMIT) begin
      sat = 16'sh7FFF;
    end else if (neg && quot > NEG_LIMIT) begin
      sat = -16'sh8000;
    end else if (neg) begin
      sat = 16'(-quot);
    end else begin
      sat = 16'(quot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_a) begin
        a_valid <= tok_valid;
      end
      if (en_b) begin
        b_valid <= a_valid;
      end
      if (en_c) begin
        out_valid <= b_valid;
      end
    end
    if (en_a) begin
      a_tok <= tok;
    end
    if (en_b) begin
      b_prod <= a_tok.raw * $signed({1'b0, volume});
      b_kind <= a_tok.kind;
      b_last <= a_tok.last;
    end
    if (en_c) begin
      sample <= sat;
      kind   <= b_kind;
      last   <= b_last;
    end
  end

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_SAMPLE |-> sample == 16'sd0 && last)
    else $error("status word carries a sample");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    a_valid && en_b |=> b_valid)
    else $error("word lost between gain stages");

endmodule
